// ===== hdl/ble_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine package
// Operation codes, status codes and beat layout shared by the list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 6;

	// input beat: value, then position, padded to whole bytes
	localparam int S_DATA_W = 40;
	// output beat: status, count, entry (exactly five bytes)
	localparam int M_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
	localparam logic [OP_W-1:0] OP_SORT_UP   = 3'd5;
	localparam logic [OP_W-1:0] OP_SORT_DN   = 3'd6;
	localparam logic [OP_W-1:0] OP_READ_OUT  = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_POS   = 2'd3;

endpackage

// ===== hdl/bounded_list_engine_with_sort_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded ordered list engine with exchange sort
// Holds up to DEPTH signed words; add, insert, remove, sort and read out
// under a small sequencer around one list memory and one signed comparator.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  -----------------------------------------
// s_*      in   s_tvalid/s_tready  s_tuser: op; s_tdata: value, position
// m_*      out  m_tvalid/m_tready  m_tdata: status, count, entry; m_tlast
//
// One beat is taken, then the block is busy until its last result beat
// leaves. Add/insert move each entry from the tail down to the target up
// one place (S_UP_RD, S_UP_WR) and then write the value (S_PUT); remove
// first moves entries down (S_DN_RD, S_DN_WR); sort makes one memory read
// and one compare per pair through the single read port; read-out reads
// each entry in turn. Every result beat waits in the output register until
// m_tready takes it, so a stalled sink lengthens the item by the stall. Reset
// clears count and sequencer; memory is not cleared, used only where written.
//
module bounded_list_engine_with_sort_unit #(
	parameter int DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ble_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] value, [37:32] position
	input  logic [ble_pkg::OP_W-1:0]       s_tuser,  // [2:0] op
	// master side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ble_pkg::M_DATA_W-1:0]   m_tdata,  // [1:0] status, [7:2] count, [39:8] entry
	output logic                           m_tlast
);

	import ble_pkg::*;

	// count holds 0..DEPTH, index holds 0..DEPTH-1
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	// width that holds both a position and count plus one
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISPATCH = 4'd1;
	localparam logic [3:0] S_UP_RD    = 4'd2;
	localparam logic [3:0] S_UP_WR    = 4'd3;
	localparam logic [3:0] S_PUT      = 4'd4;
	localparam logic [3:0] S_DN_RD    = 4'd5;
	localparam logic [3:0] S_DN_WR    = 4'd6;
	localparam logic [3:0] S_SORT_LDI = 4'd7;
	localparam logic [3:0] S_SORT_LDA = 4'd8;
	localparam logic [3:0] S_SORT_RDJ = 4'd9;
	localparam logic [3:0] S_SORT_CMP = 4'd10;
	localparam logic [3:0] S_SORT_WRI = 4'd11;
	localparam logic [3:0] S_RO_RD    = 4'd12;
	localparam logic [3:0] S_RO_LOAD  = 4'd13;
	localparam logic [3:0] S_RESP     = 4'd14;
	localparam logic [3:0] S_OUT_WAIT = 4'd15;

	logic [3:0]                state_q;
	logic [OP_W-1:0]           op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]          pos_q;
	logic [STATUS_W-1:0]       st_q;
	logic [CW-1:0]             cnt_q;   // live entry count
	logic [CW-1:0]             k_q;     // walking index for shifts and read-out
	logic [CW-1:0]             idx_q;   // insert target
	logic [CW-1:0]             i_q;     // sort outer index
	logic [CW-1:0]             j_q;     // sort inner index
	logic signed [VALUE_W-1:0] ai_q;    // running value of entry i during sort

	// list memory: one write and one registered read per cycle
	logic signed [VALUE_W-1:0] mem_q [DEPTH];
	logic signed [VALUE_W-1:0] rd_data_q;
	logic [IW-1:0]             mem_ra;
	logic [IW-1:0]             mem_wa;
	logic signed [VALUE_W-1:0] mem_wd;
	logic                      mem_we;

	// output register
	logic                      m_valid_q;
	logic [STATUS_W-1:0]       m_status_q;
	logic [COUNT_W-1:0]        m_count_q;
	logic signed [VALUE_W-1:0] m_entry_q;
	logic                      m_last_q;

	// shared signed comparator, used by the sort
	logic swap;
	always_comb begin
		if (op_q == OP_SORT_DN) begin
			swap = rd_data_q > ai_q;
		end else begin
			swap = ai_q > rd_data_q;
		end
	end

	// dispatch decode
	logic          full;
	logic          pos_bad;
	logic [CW-1:0] ins_idx;
	always_comb begin
		full    = (cnt_q == CW'(DEPTH));
		pos_bad = PW'(pos_q) > (PW'(cnt_q) + PW'(1));
		unique case (op_q)
			OP_ADD_FRONT: ins_idx = '0;
			OP_ADD_END:   ins_idx = cnt_q;
			default: begin
				if (pos_q == '0) begin
					ins_idx = '0;
				end else begin
					ins_idx = CW'(pos_q - POS_W'(1));
				end
			end
		endcase
	end

	// memory port steering
	always_comb begin
		mem_ra = k_q[IW-1:0];
		mem_wa = k_q[IW-1:0];
		mem_wd = rd_data_q;
		mem_we = 1'b0;
		unique case (state_q)
			S_UP_RD:    mem_ra = IW'(k_q - CW'(1));
			S_UP_WR:    mem_we = 1'b1;
			S_PUT: begin
				mem_wa = idx_q[IW-1:0];
				mem_wd = value_q;
				mem_we = 1'b1;
			end
			S_DN_RD:    mem_ra = IW'(k_q + CW'(1));
			S_DN_WR:    mem_we = 1'b1;
			S_SORT_LDI: mem_ra = i_q[IW-1:0];
			S_SORT_RDJ: mem_ra = j_q[IW-1:0];
			S_SORT_CMP: begin
				mem_wa = j_q[IW-1:0];
				mem_wd = ai_q;
				mem_we = swap;
			end
			S_SORT_WRI: begin
				mem_wa = i_q[IW-1:0];
				mem_wd = ai_q;
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem_q[mem_ra];
	end

	// handshake: the block takes a beat only when fully idle
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_entry_q, m_count_q, m_status_q};
	assign m_tlast  = m_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_valid_q  <= 1'b0;
			op_q       <= '0;
			value_q    <= '0;
			pos_q      <= '0;
			st_q       <= ST_OK;
			k_q        <= '0;
			idx_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			ai_q       <= '0;
			m_status_q <= ST_OK;
			m_count_q  <= '0;
			m_entry_q  <= '0;
			m_last_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						value_q <= s_tdata[VALUE_W-1:0];
						pos_q   <= s_tdata[VALUE_W+POS_W-1:VALUE_W];
						st_q    <= ST_OK;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					unique case (op_q)
						OP_ADD_FRONT, OP_ADD_END, OP_INSERT: begin
							// full wins over a bad position
							if (full) begin
								st_q    <= ST_FULL;
								state_q <= S_RESP;
							end else if (op_q == OP_INSERT && pos_bad) begin
								st_q    <= ST_POS;
								state_q <= S_RESP;
							end else begin
								k_q     <= cnt_q;
								idx_q   <= ins_idx;
								state_q <= (cnt_q > ins_idx) ? S_UP_RD : S_PUT;
							end
						end
						OP_DEL_FIRST: begin
							k_q <= '0;
							if (cnt_q == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_RESP;
							end else if (cnt_q == CW'(1)) begin
								cnt_q   <= '0;
								state_q <= S_RESP;
							end else begin
								state_q <= S_DN_RD;
							end
						end
						OP_DEL_LAST: begin
							if (cnt_q == '0) begin
								st_q <= ST_EMPTY;
							end else begin
								cnt_q <= cnt_q - CW'(1);
							end
							state_q <= S_RESP;
						end
						OP_SORT_UP, OP_SORT_DN: begin
							i_q     <= '0;
							state_q <= (cnt_q > CW'(1)) ? S_SORT_LDI : S_RESP;
						end
						default: begin
							k_q <= '0;
							if (cnt_q == '0) begin
								st_q    <= ST_EMPTY;
								state_q <= S_RESP;
							end else begin
								state_q <= S_RO_RD;
							end
						end
					endcase
				end
				// move entries up one place, from the tail down to the target
				S_UP_RD: state_q <= S_UP_WR;
				S_UP_WR: begin
					k_q     <= k_q - CW'(1);
					state_q <= ((k_q - CW'(1)) > idx_q) ? S_UP_RD : S_PUT;
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_RESP;
				end
				// move entries down one place, from the head up
				S_DN_RD: state_q <= S_DN_WR;
				S_DN_WR: begin
					k_q <= k_q + CW'(1);
					if ((CW+1)'(k_q) + (CW+1)'(2) < (CW+1)'(cnt_q)) begin
						state_q <= S_DN_RD;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				// exchange sort: hold entry i in ai_q, sweep j past it
				S_SORT_LDI: state_q <= S_SORT_LDA;
				S_SORT_LDA: begin
					ai_q    <= rd_data_q;
					j_q     <= i_q + CW'(1);
					state_q <= S_SORT_RDJ;
				end
				S_SORT_RDJ: state_q <= S_SORT_CMP;
				S_SORT_CMP: begin
					if (swap) begin
						ai_q <= rd_data_q;
					end
					if ((CW+1)'(j_q) + (CW+1)'(1) < (CW+1)'(cnt_q)) begin
						j_q     <= j_q + CW'(1);
						state_q <= S_SORT_RDJ;
					end else begin
						state_q <= S_SORT_WRI;
					end
				end
				S_SORT_WRI: begin
					if ((CW+1)'(i_q) + (CW+1)'(2) < (CW+1)'(cnt_q)) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SORT_LDI;
					end else begin
						state_q <= S_RESP;
					end
				end
				// read-out, one entry per beat
				S_RO_RD: state_q <= S_RO_LOAD;
				S_RO_LOAD: begin
					m_valid_q  <= 1'b1;
					m_status_q <= ST_OK;
					m_count_q  <= COUNT_W'(cnt_q);
					m_entry_q  <= rd_data_q;
					m_last_q   <= ((CW+1)'(k_q) + (CW+1)'(1)) == (CW+1)'(cnt_q);
					state_q    <= S_OUT_WAIT;
				end
				S_RESP: begin
					m_valid_q  <= 1'b1;
					m_status_q <= st_q;
					m_count_q  <= COUNT_W'(cnt_q);
					m_entry_q  <= '0;
					m_last_q   <= 1'b1;
					state_q    <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_RO_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken while a result beat is pending");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond DEPTH");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_status_q != ST_OK) |-> (m_tlast && m_entry_q == '0))
		else $error("error status not on a final zero-entry beat");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready stayed high after taking a beat");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not idle after the final result beat");

endmodule
